[rtl/base58_encoder_core_defines.svh]
// Assertion macros shared by the base58 encoder RTL.
`ifndef BASE58_ENCODER_CORE_DEFINES_SVH
`define BASE58_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define B58_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/b58enc_pkg.sv]
// Types, constants and the alphabet mapping for the base58 encoder.
package b58enc_pkg;

    localparam int BYTE_CNT_W   = 6;
    localparam int EMIT_CNT_W   = 6;
    localparam int RESULT_LIMIT = 48;
    localparam int RADIX        = 58;
    localparam int VAL_W        = 14;
    localparam int RECIP_W      = 15;
    localparam int RECIP        = 18079;
    localparam int RECIP_SHIFT  = 20;
    localparam int PROD_W       = VAL_W + RECIP_W;

    localparam logic [6:0] CHAR_ONE = 7'd49;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ZEROS,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_carry;
        logic rd_en;
        logic fold_wr;
        logic live;
        logic scan_chk;
        logic put_one;
        logic flush;
        logic ovf;
    } dp_cmd_t;

    typedef struct packed {
        logic produced;
    } dp_stat_t;

    // Bitcoin alphabet: digits, then letters with 0, O, I and l left out
    function automatic logic [6:0] b58_char(input logic [5:0] d);
        logic [6:0] c;
        c = {1'b0, d};
        if (d <= 6'd8)
            b58_char = 7'd49 + c;
        else if (d <= 6'd16)
            b58_char = 7'd65 + c - 7'd9;
        else if (d <= 6'd21)
            b58_char = 7'd74 + c - 7'd17;
        else if (d <= 6'd32)
            b58_char = 7'd80 + c - 7'd22;
        else if (d <= 6'd43)
            b58_char = 7'd97 + c - 7'd33;
        else if (d <= 6'd57)
            b58_char = 7'd109 + c - 7'd44;
        else
            b58_char = CHAR_ONE;
    endfunction

endpackage

[rtl/b58enc_datapath.sv]
// Digit store, multiply-by-256 fold unit and character output stage.
module b58enc_datapath
    import b58enc_pkg::*;
#(
    parameter int DIGIT_SLOTS = 49,
    localparam int ADDR_W = $clog2(DIGIT_SLOTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        data_byte,
    output dp_stat_t          stat,
    output logic              out_valid,
    output logic [6:0]        out_char,
    output logic              last_char,
    output logic              overflow
);

    logic [5:0]        mem [DIGIT_SLOTS];
    logic [5:0]        rd_data_reg;
    logic [7:0]        carry_reg;
    logic [5:0]        digit;
    logic [VAL_W-1:0]  value;
    logic [PROD_W-1:0] prod;
    logic [7:0]        quot;
    logic [VAL_W-1:0]  rem_full;
    logic [5:0]        rem;

    logic              produce;
    logic [6:0]        new_char;
    logic              emit_last;
    logic              pend_valid_reg, pend_valid_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        pend_char_reg;
    logic [6:0]        out_char_reg;
    logic              last_char_reg;
    logic              ovf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.fold_wr)
            mem[wr_addr] <= rem;
    end

    // store reads as zero until the first fold has written every slot
    assign digit    = cmd.live ? rd_data_reg : 6'd0;
    assign value    = {digit, 8'h00} + {6'h00, carry_reg};
    assign prod     = PROD_W'(value) * PROD_W'(RECIP);
    assign quot     = prod[RECIP_SHIFT +: 8];
    assign rem_full = value - ({6'h00, quot} * VAL_W'(RADIX));
    assign rem      = rem_full[5:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_carry)
            carry_reg <= data_byte;
        else if (cmd.fold_wr)
            carry_reg <= quot;
    end

    assign produce  = cmd.put_one | (cmd.scan_chk & (started_reg | (digit != 6'd0)));
    assign new_char = cmd.put_one ? CHAR_ONE : b58_char(digit);
    assign stat.produced = produce;

    // one character held back so that the final one can be marked
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        started_next    = started_reg;
        out_valid_next  = 1'b0;
        emit_last       = 1'b0;
        if (produce)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b1;
            started_next    = started_reg | cmd.scan_chk;
        end
        else if (cmd.flush)
        begin
            out_valid_next  = pend_valid_reg;
            emit_last       = 1'b1;
            pend_valid_next = 1'b0;
            started_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            started_reg    <= started_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
            pend_char_reg <= new_char;
        if (produce || cmd.flush)
        begin
            out_char_reg  <= pend_char_reg;
            last_char_reg <= emit_last;
            ovf_reg       <= cmd.ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;
    assign overflow  = ovf_reg;

endmodule

[rtl/b58enc_ctrl.sv]
// Sequencer for byte intake, digit folding and character emission.
module b58enc_ctrl
    import b58enc_pkg::*;
#(
    parameter int MAX_BYTES   = 35,
    parameter int DIGIT_SLOTS = 49,
    localparam int ADDR_W = $clog2(DIGIT_SLOTS),
    localparam int CNT_SW = $clog2(DIGIT_SLOTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              busy,
    output dp_cmd_t           cmd,
    output logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0] wr_addr,
    input  dp_stat_t          stat
);

    localparam logic [CNT_SW-1:0]     SLOTS_C  = CNT_SW'(DIGIT_SLOTS);
    localparam logic [BYTE_CNT_W-1:0] BYTE_LIM = BYTE_CNT_W'(MAX_BYTES);
    localparam logic [EMIT_CNT_W-1:0] EMIT_END = EMIT_CNT_W'(RESULT_LIMIT - 1);

    state_t                  state_reg, state_next;
    logic [CNT_SW-1:0]       slot_cnt_reg, slot_cnt_next;
    logic [BYTE_CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [BYTE_CNT_W-1:0]   zero_count_reg, zero_count_next;
    logic [EMIT_CNT_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic                    seen_nonzero_reg, seen_nonzero_next;
    logic                    overflow_flag_reg, overflow_flag_next;
    logic                    store_live_reg, store_live_next;
    logic                    last_pend_reg, last_pend_next;
    logic                    do_fold;
    logic [CNT_SW-1:0]       fold_rd_idx;
    logic [CNT_SW-1:0]       fold_wr_idx;

    // fold walks from least significant slot down to slot 0
    assign fold_rd_idx = SLOTS_C - CNT_SW'(1) - slot_cnt_reg;
    assign fold_wr_idx = SLOTS_C - slot_cnt_reg;

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            slot_cnt_reg      <= '0;
            byte_count_reg    <= '0;
            zero_count_reg    <= '0;
            emit_cnt_reg      <= '0;
            seen_nonzero_reg  <= 1'b0;
            overflow_flag_reg <= 1'b0;
            store_live_reg    <= 1'b0;
            last_pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            slot_cnt_reg      <= slot_cnt_next;
            byte_count_reg    <= byte_count_next;
            zero_count_reg    <= zero_count_next;
            emit_cnt_reg      <= emit_cnt_next;
            seen_nonzero_reg  <= seen_nonzero_next;
            overflow_flag_reg <= overflow_flag_next;
            store_live_reg    <= store_live_next;
            last_pend_reg     <= last_pend_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        slot_cnt_next      = slot_cnt_reg;
        byte_count_next    = byte_count_reg;
        zero_count_next    = zero_count_reg;
        emit_cnt_next      = emit_cnt_reg;
        seen_nonzero_next  = seen_nonzero_reg;
        overflow_flag_next = overflow_flag_reg;
        store_live_next    = store_live_reg;
        last_pend_next     = last_pend_reg;
        do_fold            = 1'b0;
        cmd                = '0;
        cmd.live           = store_live_reg;
        cmd.ovf            = overflow_flag_reg;
        rd_addr            = '0;
        wr_addr            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (byte_count_reg < BYTE_LIM)
                    begin
                        byte_count_next = byte_count_reg + 1'b1;
                        if (!seen_nonzero_reg && data_byte == 8'h00)
                            zero_count_next = zero_count_reg + 1'b1;
                        else
                            do_fold = 1'b1;
                    end
                    else
                        overflow_flag_next = 1'b1;

                    if (do_fold)
                    begin
                        seen_nonzero_next = 1'b1;
                        cmd.load_carry    = 1'b1;
                        slot_cnt_next     = '0;
                        last_pend_next    = last_byte;
                        state_next        = ST_FOLD;
                    end
                    else if (last_byte)
                        state_next = ST_ZEROS;
                end
            end

            ST_FOLD:
            begin
                cmd.rd_en   = (slot_cnt_reg != SLOTS_C);
                rd_addr     = fold_rd_idx[ADDR_W-1:0];
                cmd.fold_wr = (slot_cnt_reg != '0);
                wr_addr     = fold_wr_idx[ADDR_W-1:0];
                if (slot_cnt_reg == SLOTS_C)
                begin
                    store_live_next = 1'b1;
                    state_next      = last_pend_reg ? ST_ZEROS : ST_IDLE;
                end
                else
                    slot_cnt_next = slot_cnt_reg + 1'b1;
            end

            ST_ZEROS:
            begin
                // zero count never exceeds MAX_BYTES, below the character limit
                if (zero_count_reg == '0)
                begin
                    slot_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    cmd.put_one     = 1'b1;
                    zero_count_next = zero_count_reg - 1'b1;
                end
            end

            ST_SCAN:
            begin
                cmd.rd_en    = (slot_cnt_reg != SLOTS_C);
                rd_addr      = slot_cnt_reg[ADDR_W-1:0];
                cmd.scan_chk = (slot_cnt_reg != '0);
                if (slot_cnt_reg == SLOTS_C
                    || (cmd.scan_chk && stat.produced && emit_cnt_reg == EMIT_END))
                    state_next = ST_FLUSH;
                else
                    slot_cnt_next = slot_cnt_reg + 1'b1;
            end

            ST_FLUSH:
            begin
                cmd.flush          = 1'b1;
                byte_count_next    = '0;
                zero_count_next    = '0;
                emit_cnt_next      = '0;
                seen_nonzero_next  = 1'b0;
                overflow_flag_next = 1'b0;
                store_live_next    = 1'b0;
                last_pend_next     = 1'b0;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (stat.produced)
            emit_cnt_next = emit_cnt_reg + 1'b1;
    end

endmodule

[rtl/base58_encoder_core.sv]
// Top level of the base58 encoder: sequencer plus digit datapath.
`include "base58_encoder_core_defines.svh"

// Bytes enter most significant first on start while busy is low; last_byte marks
// the end of a string. A leading zero byte, or a byte dropped beyond MAX_BYTES,
// is handled in the idle state. Any other byte is folded into the base-58 digit
// store, one slot per cycle through a single-port-read, single-port-write
// memory, with busy high while it folds. After the last byte the block emits
// one '1' per leading zero byte, then scans the store from the most significant
// slot (stopping early once 48 characters are reached), then flushes. Characters
// appear on out_char for exactly one cycle with out_valid and cannot be held off;
// last_char marks the final one, and overflow is high on every character of a
// string that lost bytes.
module base58_encoder_core
    import b58enc_pkg::*;
#(
    parameter int MAX_BYTES   = 35,
    parameter int DIGIT_SLOTS = 49
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    output logic [6:0] out_char,
    output logic       last_char,
    output logic       overflow
);

    localparam int ADDR_W = $clog2(DIGIT_SLOTS);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    b58enc_ctrl #(
        .MAX_BYTES   (MAX_BYTES),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .busy      (busy),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .stat      (stat)
    );

    b58enc_datapath #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .data_byte (data_byte),
        .stat      (stat),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last_char (last_char),
        .overflow  (overflow)
    );

    `B58_ASSERT_NEXT(a_last_goes_busy, start && !busy && last_byte, busy, "last byte ignored")
    `B58_ASSERT_NEXT(a_final_char_ends, out_valid && last_char, !out_valid, "char after last_char")
    `B58_ASSERT_IMPLY(a_char_range, out_valid,
                      out_char >= 7'd49 && out_char <= 7'd122, "character outside alphabet")

endmodule
